[rtl/sfp_pkg.sv]
package sfp_pkg;

  // Receive FIFO and USB bulk packet sizing
  localparam int FIFO_DEPTH  = 64;
  localparam int PACKET_SIZE = 64;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int LEN_W = $clog2(PACKET_SIZE);

  localparam int BYTE_W    = 8;
  localparam int PKTLEN_W  = 6;
  localparam int THRESH_W  = 7;
  localparam int IDLE_W    = 8;

  // Register map, word index into the APB window
  localparam logic [1:0] REG_FLUSH_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_IDLE_POLL_LIMIT = 2'd1;
  localparam logic [1:0] REG_BRIDGE_ENABLED  = 2'd2;

  localparam logic [THRESH_W-1:0] FLUSH_THRESHOLD_RST = THRESH_W'(32);
  localparam logic [IDLE_W-1:0]   IDLE_POLL_LIMIT_RST = IDLE_W'(20);

  // Input word kinds
  typedef enum logic [1:0] {
    OP_RX_BYTE   = 2'd0,
    OP_POLL      = 2'd1,
    OP_PKT_SENT  = 2'd2,
    OP_BUS_RESET = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic [THRESH_W-1:0] flush_threshold;
    logic [IDLE_W-1:0]   idle_poll_limit;
    logic                bridge_enabled;
  } cfg_t;

  // One FIFO read issued toward the output stage
  typedef struct packed {
    logic                en;
    logic [PTR_W-1:0]    addr;
    logic                last;
    logic [PKTLEN_W-1:0] len;
  } rd_req_t;

endpackage

[rtl/sfp_ram.sv]
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/sfp_cfg.sv]
module sfp_cfg
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // register writes, masked to register width
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FLUSH_THRESHOLD: cfg_nxt.flush_threshold = pwdata[THRESH_W-1:0];
        REG_IDLE_POLL_LIMIT: cfg_nxt.idle_poll_limit = pwdata[IDLE_W-1:0];
        REG_BRIDGE_ENABLED:  cfg_nxt.bridge_enabled  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flush_threshold <= FLUSH_THRESHOLD_RST;
      cfg_r.idle_poll_limit <= IDLE_POLL_LIMIT_RST;
      cfg_r.bridge_enabled  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_FLUSH_THRESHOLD: prdata = 32'(cfg_r.flush_threshold);
      REG_IDLE_POLL_LIMIT: prdata = 32'(cfg_r.idle_poll_limit);
      REG_BRIDGE_ENABLED:  prdata = 32'(cfg_r.bridge_enabled);
      default:             prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[rtl/sfp_ctrl.sv]
module sfp_ctrl
  import sfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  op_t               in_op,
  input  logic [BYTE_W-1:0] in_byte,
  input  cfg_t              cfg,
  input  logic              rd_ready,
  output rd_req_t           rd,
  output logic              ram_we,
  output logic [PTR_W-1:0]  ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata
);

  localparam int TH_W = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;
  localparam int L_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  state_t               state_r, state_nxt;
  logic [PTR_W-1:0]     wptr_r, wptr_nxt;
  logic [PTR_W-1:0]     rptr_r, rptr_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic                 busy_r, busy_nxt;
  logic [IDLE_W-1:0]    idle_r, idle_nxt;
  logic [LEN_W-1:0]     remain_r, remain_nxt;
  logic [PKTLEN_W-1:0]  pkt_len_r, pkt_len_nxt;

  logic                 fifo_full;
  logic                 flush_hit;
  logic [L_W-1:0]       start_len;
  logic [L_W-1:0]       fill_ext;
  logic [L_W-1:0]       len_cap;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign fifo_full = (fill_r == CNT_W'(FIFO_DEPTH));
  assign flush_hit = (idle_r > cfg.idle_poll_limit) ||
                     (TH_W'(fill_r) >= TH_W'(cfg.flush_threshold));

  // packet length: fill count capped at one short of the endpoint size
  assign fill_ext  = L_W'(fill_r);
  assign len_cap   = L_W'(PACKET_SIZE - 1);
  assign start_len = (fill_ext < len_cap) ? fill_ext : len_cap;

  assign ram_waddr = wptr_r;
  assign ram_wdata = in_byte;

  // sequencer: take words while idle, pop one byte a cycle while streaming and rd_ready is high
  always_comb begin
    state_nxt   = state_r;
    wptr_nxt    = wptr_r;
    rptr_nxt    = rptr_r;
    fill_nxt    = fill_r;
    busy_nxt    = busy_r;
    idle_nxt    = idle_r;
    remain_nxt  = remain_r;
    pkt_len_nxt = pkt_len_r;
    ram_we      = 1'b0;
    rd          = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op) inside
            OP_RX_BYTE: begin
              if (!fifo_full) begin
                ram_we   = 1'b1;
                wptr_nxt = ptr_inc(wptr_r);
                fill_nxt = fill_r + CNT_W'(1);
              end
            end
            OP_POLL: begin
              if (cfg.bridge_enabled && (fill_r != '0) && !busy_r) begin
                if (flush_hit) begin
                  busy_nxt    = 1'b1;
                  idle_nxt    = '0;
                  remain_nxt  = LEN_W'(start_len);
                  pkt_len_nxt = PKTLEN_W'(start_len);
                  state_nxt   = ST_STREAM;
                end else if (idle_r != '1) begin
                  idle_nxt = idle_r + IDLE_W'(1);
                end
              end
            end
            OP_PKT_SENT, OP_BUS_RESET: begin
              busy_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_STREAM: begin
        if (rd_ready) begin
          rd.en      = 1'b1;
          rd.addr    = rptr_r;
          rd.last    = (remain_r == LEN_W'(1));
          rd.len     = pkt_len_r;
          rptr_nxt   = ptr_inc(rptr_r);
          fill_nxt   = fill_r - CNT_W'(1);
          remain_nxt = remain_r - LEN_W'(1);
          if (remain_r == LEN_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wptr_r   <= '0;
      rptr_r   <= '0;
      fill_r   <= '0;
      busy_r   <= 1'b0;
      idle_r   <= '0;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      wptr_r   <= wptr_nxt;
      rptr_r   <= rptr_nxt;
      fill_r   <= fill_nxt;
      busy_r   <= busy_nxt;
      idle_r   <= idle_nxt;
      remain_r <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_len_r <= pkt_len_nxt;
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(FIFO_DEPTH))
    else $error("fill count beyond FIFO depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> wptr_r == rptr_r)
    else $error("empty FIFO with pointers apart");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd.en |-> busy_r && fill_r != '0)
    else $error("FIFO read outside a packet or from empty FIFO");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    rd.en && rd.last |=> state_r == ST_IDLE)
    else $error("stream did not end after last byte");

endmodule

[rtl/serial_rx_fifo_packetizer.sv]
// Serial receive FIFO to USB bulk packetizer, one bridge channel.
//
// Input channel in_*: one word per event. in_tuser carries the kind (serial
// byte, poll tick, packet sent, bus reset), in_tdata the received byte.
// Output channel out_*: one word per packet byte, oldest byte first; tlast
// marks the final byte and tdata carries the packet length on every byte.
// Configuration: APB registers flush threshold (0x0), idle poll limit
// (0x4) and bridge enable (0x8); pready is tied high.
//
// Input words are taken only while idle. A flushing poll holds in_tready
// low while its bytes are read through the FIFO memory's single read port,
// one byte per cycle unless out_* stalls; the first byte passes the state,
// memory read and output registers. A stalled receiver stops the FIFO reads
// and the packet resumes without loss once out_tready returns.
// Reset (rst_n, synchronous) empties the FIFO, clears the busy flag and the
// idle counter and loads the register defaults; the FIFO memory needs no
// clearing pass, so input is taken right after reset.
module serial_rx_fifo_packetizer
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] packet_byte, [13:8] packet_length
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t                cfg;
  rd_req_t             rd;
  logic                rd_ready;
  logic                ram_we;
  logic [PTR_W-1:0]    ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [BYTE_W-1:0]   ram_rdata;

  // read data stage (memory output) and output register
  logic                dout_valid_r, dout_valid_nxt;
  logic                dout_last_r;
  logic [PKTLEN_W-1:0] dout_len_r;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_last_r;
  logic [PKTLEN_W-1:0] out_len_r;
  logic                consume;

  sfp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tuser)),
    .in_byte   (in_tdata),
    .cfg       (cfg),
    .rd_ready  (rd_ready),
    .rd        (rd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  sfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (ram_rdata)
  );

  // memory data moves on when the output register is free or draining
  assign consume  = dout_valid_r && (!out_valid_r || out_tready);
  assign rd_ready = !dout_valid_r || consume;

  always_comb begin
    dout_valid_nxt = dout_valid_r;
    if (rd.en) begin
      dout_valid_nxt = 1'b1;
    end else if (consume) begin
      dout_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (consume) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      dout_valid_r <= dout_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd.en) begin
      dout_last_r <= rd.last;
      dout_len_r  <= rd.len;
    end
    if (consume) begin
      out_byte_r <= ram_rdata;
      out_last_r <= dout_last_r;
      out_len_r  <= dout_len_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_len_r, out_byte_r};

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    dout_valid_r && !consume |-> !rd.en)
    else $error("FIFO read overwrote pending read data");

endmodule

[dv/tb_serial_rx_fifo_packetizer.sv]
module tb_serial_rx_fifo_packetizer;
  import sfp_pkg::*;

  // one input word: kind plus received byte
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } rx_word_t;

  // one expected packet byte
  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last;
    logic [5:0] len;
  } pkt_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] rx_byte
  logic [1:0]  in_tuser = '0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] packet_byte, [13:8] packet_length
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  serial_rx_fifo_packetizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the bridge channel
  // ---------------------------------------------------------------------------
  logic [7:0]  rx_fifo [FIFO_DEPTH];
  int unsigned rx_wr_ptr = 0;
  int unsigned rx_rd_ptr = 0;
  int unsigned rx_fill = 0;
  int unsigned idle_cnt = 0;
  bit          pkt_in_flight = 1'b0;
  logic [6:0]  flush_thr;
  logic [7:0]  idle_lim;
  bit          bridge_on;

  pkt_word_t   pkt_bytes_q[$];   // packet bytes still due on out_*
  rx_word_t    word_q[$];        // words waiting to be offered on in_*

  int unsigned words_taken, bytes_seen, pkts_made, bytes_dropped, fail_count;
  int unsigned words_sent;

  // apply one accepted input word to the shadow state
  task automatic packetize(rx_word_t w);
    int unsigned n;
    case (w.op)
      OP_RX_BYTE: begin
        if (rx_fill < FIFO_DEPTH) begin
          rx_fifo[rx_wr_ptr] = w.data;
          rx_wr_ptr = (rx_wr_ptr + 1) % FIFO_DEPTH;
          rx_fill++;
        end else begin
          bytes_dropped++;
        end
      end
      OP_PKT_SENT, OP_BUS_RESET: pkt_in_flight = 1'b0;
      default: begin
        if (bridge_on && rx_fill != 0 && !pkt_in_flight) begin
          if (idle_cnt > idle_lim || rx_fill >= flush_thr) begin
            n = (rx_fill > PACKET_SIZE - 1) ? PACKET_SIZE - 1 : rx_fill;
            for (int unsigned i = 0; i < n; i++) begin
              pkt_bytes_q.push_back('{pkt_byte: rx_fifo[rx_rd_ptr],
                                      last: (i + 1 == n), len: n[5:0]});
              rx_rd_ptr = (rx_rd_ptr + 1) % FIFO_DEPTH;
              rx_fill--;
            end
            pkt_in_flight = 1'b1;
            idle_cnt = 0;
            pkts_made++;
          end else if (idle_cnt < 255) begin
            idle_cnt++;
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side: bursty sender
  // ---------------------------------------------------------------------------
  rx_word_t drv_word;
  int       burst_left, gap_left;

  // a new word goes out only once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (words_sent == words_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (word_q.size() != 0) begin
        drv_word = word_q.pop_front();
        in_tdata  <= drv_word.data;
        in_tuser  <= drv_word.op;
        in_tvalid <= 1'b1;
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // word taken by the block
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      packetize(drv_word);
      words_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall pattern plus requested long hold-off
  // ---------------------------------------------------------------------------
  int hold_req, hold_seen, hold_left, seg_left, seg_mode;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 400;
      out_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 64);
        seg_mode = $urandom_range(0, 2);
      end
      seg_left--;
      case (seg_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // check each packet byte against the oldest expected one
  pkt_word_t exp_word;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pkt_bytes_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected output word: tdata=%h tlast=%b", out_tdata, out_tlast);
      end else begin
        exp_word = pkt_bytes_q.pop_front();
        bytes_seen++;
        if (out_tdata !== {2'b00, exp_word.len, exp_word.pkt_byte} ||
            out_tlast !== exp_word.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("byte %0d mismatch: exp byte=%h len=%0d last=%b",
                     bytes_seen, exp_word.pkt_byte, exp_word.len, exp_word.last);
            $display("  got byte=%h len=%0d last=%b pad=%b",
                     out_tdata[7:0], out_tdata[13:8], out_tlast, out_tdata[15:14]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_word(op_t op, logic [7:0] d);
    word_q.push_back('{op: op, data: d});
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_FLUSH_THRESHOLD: flush_thr = val[6:0];
      REG_IDLE_POLL_LIMIT: idle_lim  = val[7:0];
      REG_BRIDGE_ENABLED:  bridge_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // wait until every word is taken and every packet byte is out, plus margin
  task automatic settle();
    while (word_q.size() != 0 || words_sent != words_taken || pkt_bytes_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_regs(logic [6:0] thr, logic [7:0] lim, bit en);
    cfg_write(REG_FLUSH_THRESHOLD, {25'd0, thr});
    cfg_write(REG_IDLE_POLL_LIMIT, {24'd0, lim});
    cfg_write(REG_BRIDGE_ENABLED, {31'd0, en});
  endtask

  // mostly byte runs followed by polls and a packet-sent or bus reset, some loose noise
  task automatic gen_traffic(int n, int max_polls);
    int added;
    int nb;
    int np;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 9) < 7) begin
        nb = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12);
        np = $urandom_range(1, max_polls);
        repeat (nb) add_word(OP_RX_BYTE, 8'($urandom_range(0, 255)));
        repeat (np) add_word(OP_POLL, 8'($urandom_range(0, 255)));
        add_word(($urandom_range(0, 3) == 0) ? OP_BUS_RESET : OP_PKT_SENT,
                 8'($urandom_range(0, 255)));
        added += nb + np + 1;
      end else begin
        add_word(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        added++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    flush_thr = FLUSH_THRESHOLD_RST;
    idle_lim  = IDLE_POLL_LIMIT_RST;
    bridge_on = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults, bridge disabled: polls do nothing
    add_word(OP_RX_BYTE, 8'h00);
    add_word(OP_RX_BYTE, 8'hFF);
    add_word(OP_POLL, 8'h00);
    add_word(OP_POLL, 8'hFF);
    settle();

    // threshold of zero: any non-empty FIFO flushes on the first poll
    set_regs(7'd0, 8'd0, 1'b1);
    add_word(OP_POLL, 8'h12);        // flushes the two bytes
    add_word(OP_POLL, 8'h00);        // busy, ignored
    add_word(OP_RX_BYTE, 8'hA5);
    add_word(OP_BUS_RESET, 8'h00);   // clears busy only
    add_word(OP_POLL, 8'h00);
    add_word(OP_PKT_SENT, 8'h00);
    add_word(OP_POLL, 8'h00);        // empty FIFO
    add_word(OP_RX_BYTE, 8'h5A);
    add_word(OP_RX_BYTE, 8'h3C);
    add_word(OP_POLL, 8'hFF);
    add_word(OP_POLL, 8'h00);
    add_word(OP_PKT_SENT, 8'hFF);
    settle();

    // idle timeout flush, then threshold flush
    set_regs(7'd3, 8'd2, 1'b1);
    add_word(OP_RX_BYTE, 8'h81);
    add_word(OP_RX_BYTE, 8'h7E);
    repeat (4) add_word(OP_POLL, 8'h00);
    add_word(OP_PKT_SENT, 8'h00);
    add_word(OP_RX_BYTE, 8'h01);
    add_word(OP_RX_BYTE, 8'h80);
    add_word(OP_RX_BYTE, 8'h55);
    add_word(OP_POLL, 8'h00);
    add_word(OP_PKT_SENT, 8'h00);
    settle();

    // defaults, enabled
    set_regs(7'd32, 8'd20, 1'b1);
    gen_traffic(30, 24);
    settle();

    set_regs(7'd0, 8'd0, 1'b1);
    gen_traffic(40, 3);
    settle();

    // full FIFO drops bytes; idle limit 255 leaves only the threshold
    set_regs(7'd64, 8'd255, 1'b1);
    repeat (66) add_word(OP_RX_BYTE, 8'($urandom_range(0, 255)));
    add_word(OP_POLL, 8'h00);
    add_word(OP_PKT_SENT, 8'h00);
    gen_traffic(20, 4);
    settle();

    set_regs(7'd1, 8'd254, 1'b1);
    gen_traffic(30, 3);
    settle();

    // disabled: polls ignored, FIFO may overflow
    set_regs(7'd127, 8'd5, 1'b0);
    gen_traffic(20, 4);
    settle();

    // long receiver hold-off while the sender keeps going
    set_regs(7'd10, 8'd7, 1'b1);
    gen_traffic(45, 10);
    hold_req++;
    settle();

    $display("%0d words in, %0d packets / %0d bytes checked, %0d bytes dropped on full FIFO",
             words_taken, pkts_made, bytes_seen, bytes_dropped);
    if (fail_count == 0 && pkt_bytes_q.size() == 0) begin
      $display("tb_serial_rx_fifo_packetizer: clean");
    end else begin
      $display("tb_serial_rx_fifo_packetizer: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("timeout: %0d packet bytes still due", pkt_bytes_q.size());
    $display("tb_serial_rx_fifo_packetizer: errors");
    $finish;
  end

endmodule
